[rtl/core/u8dec_pkg.sv]
// Shared types and byte-class constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package u8dec_pkg;

  // Width of a decoded codepoint.
  localparam int unsigned CpW = 21;

  // Byte-class masks and the tags they must match.
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] AsciiMask = 8'h80;
  localparam logic [7:0] AsciiTag  = 8'h00;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag  = 8'hF0;

  // Payload bits carried by each kind of byte.
  localparam logic [7:0] ContData  = 8'h3F;
  localparam logic [7:0] Lead2Data = 8'h1F;
  localparam logic [7:0] Lead3Data = 8'h0F;
  localparam logic [7:0] Lead4Data = 8'h07;

  // Continuation counts opened by each lead byte.
  localparam logic [1:0] RemNone  = 2'd0;
  localparam logic [1:0] RemLead2 = 2'd1;
  localparam logic [1:0] RemLead3 = 2'd2;
  localparam logic [1:0] RemLead4 = 2'd3;

  // One result word as it travels from the decode step to the output register.
  typedef struct packed {
    logic [CpW-1:0] codepoint;
    logic           present;
    logic           eos;
    logic           str_valid;
  } u8dec_res_t;

endpackage

`default_nettype wire

[rtl/core/u8dec_step.sv]
// Input register, sequence state and the single-pass decode step.
// Depends on u8dec_pkg for byte classes and the result word type.
`default_nettype none

module u8dec_step (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output u8dec_pkg::u8dec_res_t  res_o
);
  import u8dec_pkg::*;

  logic           in_valid_q;
  logic [7:0]     byte_q;
  logic           last_q;

  logic [CpW-1:0] partial_q, partial_d;
  logic [1:0]     rem_q, rem_d;
  logic           err_q, err_d;

  logic           present;
  logic [CpW-1:0] cp;
  logic [CpW-1:0] shifted;
  logic [1:0]     rem_dec;
  logic           err_fin;
  logic           has_res;
  logic           advance;

  // Decode the held word against the pending sequence.
  always_comb begin
    present   = 1'b0;
    cp        = '0;
    partial_d = '0;
    rem_d     = RemNone;
    err_d     = err_q;
    shifted   = {partial_q[CpW-7:0], byte_q[5:0] & ContData[5:0]};
    rem_dec   = rem_q - 2'd1;
    if (rem_q != RemNone && (byte_q & ContMask) == ContTag) begin
      rem_d = rem_dec;
      if (rem_dec == RemNone) begin
        present = 1'b1;
        cp      = shifted;
      end else begin
        partial_d = shifted;
      end
    end else begin
      // A broken sequence is dropped before the word is decoded as ASCII or a lead.
      if (rem_q != RemNone) begin
        err_d = 1'b1;
      end
      priority if ((byte_q & AsciiMask) == AsciiTag) begin
        present = 1'b1;
        cp      = {{(CpW-8){1'b0}}, byte_q};
      end else if ((byte_q & Lead2Mask) == Lead2Tag) begin
        partial_d = {{(CpW-8){1'b0}}, byte_q & Lead2Data};
        rem_d     = RemLead2;
      end else if ((byte_q & Lead3Mask) == Lead3Tag) begin
        partial_d = {{(CpW-8){1'b0}}, byte_q & Lead3Data};
        rem_d     = RemLead3;
      end else if ((byte_q & Lead4Mask) == Lead4Tag) begin
        partial_d = {{(CpW-8){1'b0}}, byte_q & Lead4Data};
        rem_d     = RemLead4;
      end else begin
        err_d = 1'b1;
      end
    end
    // A sequence cut off by the end of the string counts as a drop.
    err_fin = err_d | (rem_d != RemNone);
  end

  // Result word and handshake toward the output register.
  assign has_res     = present | last_q;
  assign res_valid_o = in_valid_q & has_res;
  assign advance     = in_valid_q & (~has_res | res_ready_i);
  assign in_ready_o  = ~in_valid_q | advance;

  always_comb begin
    res_o.codepoint = cp;
    res_o.present   = present;
    res_o.eos       = last_q;
    res_o.str_valid = last_q & ~err_fin;
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // Sequence state; the last word of a string returns it to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      rem_q     <= RemNone;
      err_q     <= 1'b0;
    end else if (advance) begin
      if (last_q) begin
        partial_q <= '0;
        rem_q     <= RemNone;
        err_q     <= 1'b0;
      end else begin
        partial_q <= partial_d;
        rem_q     <= rem_d;
        err_q     <= err_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/u8dec_out_reg.sv]
// Output register that holds one decoded result until it is taken.
// Depends on u8dec_pkg for the result word type.
`default_nettype none

module u8dec_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  output logic                   res_ready_o,
  input  u8dec_pkg::u8dec_res_t  res_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [u8dec_pkg::CpW-1:0] codepoint_o,
  output logic                   codepoint_present_o,
  output logic                   end_of_string_o,
  output logic                   string_valid_o
);
  import u8dec_pkg::*;

  logic       out_valid_q;
  u8dec_res_t res_q;

  // The slot takes a new word when empty or when its word leaves this cycle.
  assign res_ready_o = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign codepoint_o         = res_q.codepoint;
  assign codepoint_present_o = res_q.present;
  assign end_of_string_o     = res_q.eos;
  assign string_valid_o      = res_q.str_valid;

endmodule

`default_nettype wire

[rtl/core/utf8_stream_decoder.sv]
// UTF-8 stream decoder: one byte word in, zero or one codepoint word out.
// A result passes from the input register through the decode step into the output
// register, where it is offered.
// Throughput: one byte per cycle, limited only by output backpressure.
// Reset clears all valid flags and the sequence state; no clearing pass.
`default_nettype none

module utf8_stream_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [u8dec_pkg::CpW-1:0] codepoint_o,
  output logic                      codepoint_present_o,
  output logic                      end_of_string_o,
  output logic                      string_valid_o
);
  import u8dec_pkg::*;

  logic       res_valid;
  logic       res_ready;
  u8dec_res_t res;

  // Input register, sequence state and decode.
  u8dec_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register.
  u8dec_out_reg u_out (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .res_valid_i         (res_valid),
    .res_ready_o         (res_ready),
    .res_i               (res),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .codepoint_o         (codepoint_o),
    .codepoint_present_o (codepoint_present_o),
    .end_of_string_o     (end_of_string_o),
    .string_valid_o      (string_valid_o)
  );

  // A word without a codepoint is only ever the end-of-string word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !codepoint_present_o |-> end_of_string_o)
    else $error("result word carries neither a codepoint nor end of string");

  // An end word without a codepoint reports a zero codepoint.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !codepoint_present_o |-> codepoint_o == '0)
    else $error("codepoint not zero on a word without a codepoint");

  // The string-valid flag is only raised on the end word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_string_o |-> !string_valid_o)
    else $error("string valid raised before end of string");

endmodule

`default_nettype wire
